// ===== src/gbs_pkg.sv =====
package gbs_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] REG_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_MODE      = 8'd1;

    // overlap modes
    localparam logic [1:0] MODE_IOU = 2'd0;
    localparam logic [1:0] MODE_IOS = 2'd1;

    localparam int THR_BITS  = 16;
    localparam int MODE_BITS = 2;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd32768;
    localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_IOU;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RK_I,
        ST_RK_ILAT,
        ST_RK_J,
        ST_RK_JCMP,
        ST_RK_WR,
        ST_SP_I,
        ST_SP_IR,
        ST_SP_IB,
        ST_SP_J,
        ST_SP_JR,
        ST_SP_JB,
        ST_SP_OV,
        ST_SP_EMIT,
        ST_CLEAR
    } gbs_state_t;

    // result of one pairwise overlap test
    typedef struct packed {
        logic done;
        logic suppress;
    } gbs_ov_res_t;

endpackage

// ===== src/gbs_overlap.sv =====
module gbs_overlap import gbs_pkg::*; #(
    parameter int COORD_BITS = 14
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [4*COORD_BITS-1:0] box_a,
    input  logic [4*COORD_BITS-1:0] box_b,
    input  logic [MODE_BITS-1:0]    mode,
    input  logic [THR_BITS-1:0]     threshold,
    output gbs_ov_res_t             res
);

    localparam int C  = COORD_BITS;
    localparam int EW = C + 2;          // signed edge length
    localparam int LW = C + 1;          // positive edge length
    localparam int QW = 2 * LW;         // length product
    localparam int AW = 2 * C + 1;      // area
    localparam int DW = 2 * C + 2;      // denominator
    localparam int PW = THR_BITS + DW;  // compared products

    logic signed [C-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic signed [C-1:0] il, it, ir, ib;
    logic signed [EW-1:0] w, h, wa, ha, wb, hb;

    logic [3:0] vld_reg;
    logic signed [EW-1:0] w_reg, h_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic hit1_reg, hit2_reg, hit3_reg, hit4_reg;
    logic [AW-1:0] inter2_reg, a2_reg, b2_reg;
    logic [AW-1:0] inter3_reg, inter4_reg;
    logic [DW-1:0] den3_reg;
    logic [PW-1:0] prod4_reg;
    logic [QW-1:0] p_inter, p_a, p_b;
    logic [DW-1:0] den_next;
    logic hit3_next;

    assign al = box_a[C-1:0];
    assign at = box_a[2*C-1:C];
    assign ar = box_a[3*C-1:2*C];
    assign ab = box_a[4*C-1:3*C];
    assign bl = box_b[C-1:0];
    assign bt = box_b[2*C-1:C];
    assign br = box_b[3*C-1:2*C];
    assign bb = box_b[4*C-1:3*C];

    // intersection corners and edge lengths
    assign il = (al > bl) ? al : bl;
    assign it = (at > bt) ? at : bt;
    assign ir = (ar < br) ? ar : br;
    assign ib = (ab < bb) ? ab : bb;
    assign w  = EW'(ir) - EW'(il) + EW'(1);
    assign h  = EW'(ib) - EW'(it) + EW'(1);
    assign wa = EW'(ar) - EW'(al) + EW'(1);
    assign ha = EW'(ab) - EW'(at) + EW'(1);
    assign wb = EW'(br) - EW'(bl) + EW'(1);
    assign hb = EW'(bb) - EW'(bt) + EW'(1);

    // lengths are positive whenever the pair intersects
    assign p_inter = QW'(w_reg[LW-1:0]) * QW'(h_reg[LW-1:0]);
    assign p_a     = QW'(wa_reg[LW-1:0]) * QW'(ha_reg[LW-1:0]);
    assign p_b     = QW'(wb_reg[LW-1:0]) * QW'(hb_reg[LW-1:0]);

    // denominator per mode
    always_comb begin
        den_next  = '0;
        hit3_next = hit2_reg;
        case (mode)
            MODE_IOU: den_next = DW'(a2_reg) + DW'(b2_reg) - DW'(inter2_reg);
            MODE_IOS: den_next = (a2_reg < b2_reg) ? DW'(a2_reg) : DW'(b2_reg);
            default:  hit3_next = 1'b0;
        endcase
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // four register stages: lengths, areas, denominator, scaled denominator
    always_ff @(posedge aclk) begin
        w_reg      <= w;
        h_reg      <= h;
        wa_reg     <= wa;
        ha_reg     <= ha;
        wb_reg     <= wb;
        hb_reg     <= hb;
        hit1_reg   <= (w > 0) && (h > 0);
        inter2_reg <= p_inter[AW-1:0];
        a2_reg     <= p_a[AW-1:0];
        b2_reg     <= p_b[AW-1:0];
        hit2_reg   <= hit1_reg;
        inter3_reg <= inter2_reg;
        den3_reg   <= den_next;
        hit3_reg   <= hit3_next;
        inter4_reg <= inter3_reg;
        prod4_reg  <= PW'(threshold) * PW'(den3_reg);
        hit4_reg   <= hit3_reg;
    end

    assign res.done     = vld_reg[3];
    assign res.suppress = hit4_reg &&
                          ({PW'(inter4_reg), THR_BITS'(0)} > {THR_BITS'(0), prod4_reg});

endmodule

// ===== src/greedy_box_suppression_unit.sv =====
// channel  | direction | beat contents
// s_       | in        | tdata: left, top, right, bottom, confidence; tlast: set_end
// m_       | out       | tdata: kept box and score; tlast: final_box; tuser: set_overflowed
// cfg_     | in        | register index and data, taken in any cycle out of reset
//
// Loading accepts one box per cycle. After the closing box the block ranks the set with
// one box memory read per pair, then walks the ranking; for each kept box it makes two
// chained memory reads and, when the mode is IoU or IoS, a pass through the four-stage
// overlap pipeline per later unsuppressed box, and steps over each later suppressed box.
// A stalled result holds the block; after the last result the walk steps over the
// remaining suppressed boxes and then clears the set. Reset leaves an empty set and
// reset registers; ready stays low during reset.
module greedy_box_suppression_unit import gbs_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 14,
    parameter int SCORE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // left, top, right, bottom, confidence, zero fill
    input  logic [((4*COORD_BITS+SCORE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                         s_tlast,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // kept_left, kept_top, kept_right, kept_bottom, kept_confidence, zero fill
    output logic [((4*COORD_BITS+SCORE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                         m_tlast,
    // set_overflowed
    output logic                                         m_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [7:0]                                   cfg_index,
    input  logic [15:0]                                  cfg_data
);

    localparam int CW   = 4 * COORD_BITS;
    localparam int BW   = CW + SCORE_BITS;
    localparam int IDXW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam logic [CNTW-1:0] CAP = CNTW'(MAX_BOXES);

    gbs_state_t state_reg, state_next;

    logic [BW-1:0]   box_mem  [MAX_BOXES];
    logic [IDXW-1:0] rank_mem [MAX_BOXES];
    logic [BW-1:0]   box_rd_reg;
    logic [IDXW-1:0] rank_rd_reg;

    logic [CNTW-1:0] n_reg, i_reg, j_reg, cnt_reg;
    logic            ovf_reg;
    logic [SCORE_BITS-1:0] score_i_reg;
    logic [BW-1:0]   box_a_reg;
    logic [MAX_BOXES-1:0] marks_reg;
    logic [THR_BITS-1:0]  thr_reg;
    logic [MODE_BITS-1:0] mode_reg;

    logic            box_wr_en, box_rd_en, rank_wr_en, rank_rd_en, ov_start;
    logic [IDXW-1:0] box_rd_addr, rank_rd_addr;
    logic            in_beat, out_beat, last_kept, earlier;
    logic [SCORE_BITS-1:0] score_j;
    gbs_ov_res_t     ov_res;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign score_j  = box_rd_reg[BW-1:CW];
    assign earlier  = (score_j > score_i_reg) ||
                      ((score_j == score_i_reg) && (j_reg < i_reg));
    assign cfg_ready = aresetn;

    // no unsuppressed box ranked after the current one
    always_comb begin
        last_kept = 1'b1;
        for (int k = 0; k < MAX_BOXES; k++) begin
            if ((CNTW'(k) > i_reg) && (CNTW'(k) < n_reg) && !marks_reg[k])
                last_kept = 1'b0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:    if (in_beat && s_tlast) state_next = ST_RK_I;
            ST_RK_I:    state_next = ST_RK_ILAT;
            ST_RK_ILAT: state_next = ST_RK_J;
            ST_RK_J:    state_next = (j_reg == n_reg) ? ST_RK_WR : ST_RK_JCMP;
            ST_RK_JCMP: state_next = ST_RK_J;
            ST_RK_WR:   state_next = (i_reg + 1'b1 == n_reg) ? ST_SP_I : ST_RK_I;
            ST_SP_I: begin
                if (i_reg == n_reg)
                    state_next = ST_CLEAR;
                else if (!marks_reg[i_reg[IDXW-1:0]])
                    state_next = ST_SP_IR;
            end
            ST_SP_IR:   state_next = ST_SP_IB;
            ST_SP_IB:   state_next = ST_SP_J;
            ST_SP_J: begin
                if (j_reg == n_reg)
                    state_next = ST_SP_EMIT;
                else if (!marks_reg[j_reg[IDXW-1:0]] &&
                         (mode_reg == MODE_IOU || mode_reg == MODE_IOS))
                    state_next = ST_SP_JR;
            end
            ST_SP_JR:   state_next = ST_SP_JB;
            ST_SP_JB:   state_next = ST_SP_OV;
            ST_SP_OV:   if (ov_res.done) state_next = ST_SP_J;
            ST_SP_EMIT: if (m_tready) state_next = ST_SP_I;
            ST_CLEAR:   state_next = ST_LOAD;
            default:    state_next = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        box_wr_en    = 1'b0;
        box_rd_en    = 1'b0;
        box_rd_addr  = i_reg[IDXW-1:0];
        rank_wr_en   = 1'b0;
        rank_rd_en   = 1'b0;
        rank_rd_addr = i_reg[IDXW-1:0];
        ov_start     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready  = aresetn;
                box_wr_en = s_tvalid && (n_reg < CAP);
            end
            ST_RK_I:    box_rd_en = 1'b1;
            ST_RK_JCMP: ;
            ST_RK_J: begin
                box_rd_en   = (j_reg != n_reg);
                box_rd_addr = j_reg[IDXW-1:0];
            end
            ST_RK_WR:   rank_wr_en = 1'b1;
            ST_SP_I:    rank_rd_en = 1'b1;
            ST_SP_IR: begin
                box_rd_en   = 1'b1;
                box_rd_addr = rank_rd_reg;
            end
            ST_SP_J: begin
                rank_rd_en   = 1'b1;
                rank_rd_addr = j_reg[IDXW-1:0];
            end
            ST_SP_JR: begin
                box_rd_en   = 1'b1;
                box_rd_addr = rank_rd_reg;
            end
            ST_SP_JB:   ov_start = 1'b1;
            ST_SP_EMIT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    // box and rank memories, registered reads
    always_ff @(posedge aclk) begin
        if (box_wr_en)
            box_mem[n_reg[IDXW-1:0]] <= s_tdata[BW-1:0];
        if (box_rd_en)
            box_rd_reg <= box_mem[box_rd_addr];
        if (rank_wr_en)
            rank_mem[cnt_reg[IDXW-1:0]] <= i_reg[IDXW-1:0];
        if (rank_rd_en)
            rank_rd_reg <= rank_mem[rank_rd_addr];
    end

    // control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            marks_reg <= '0;
            thr_reg   <= THR_RESET;
            mode_reg  <= MODE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == REG_THRESHOLD)
                    thr_reg <= cfg_data[THR_BITS-1:0];
                else if (cfg_index == REG_MODE)
                    mode_reg <= cfg_data[MODE_BITS-1:0];
            end
            case (state_reg)
                ST_LOAD: begin
                    if (in_beat) begin
                        if (n_reg < CAP)
                            n_reg <= n_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        i_reg <= '0;
                    end
                end
                ST_RK_ILAT: begin
                    j_reg   <= '0;
                    cnt_reg <= '0;
                end
                ST_RK_JCMP: begin
                    if (earlier)
                        cnt_reg <= cnt_reg + 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                ST_RK_WR: i_reg <= (i_reg + 1'b1 == n_reg) ? '0 : i_reg + 1'b1;
                ST_SP_I: begin
                    if (i_reg != n_reg && marks_reg[i_reg[IDXW-1:0]])
                        i_reg <= i_reg + 1'b1;
                end
                ST_SP_IB: begin
                    marks_reg[i_reg[IDXW-1:0]] <= 1'b1;
                    j_reg <= i_reg + 1'b1;
                end
                ST_SP_J: begin
                    if (j_reg != n_reg && state_next == ST_SP_J)
                        j_reg <= j_reg + 1'b1;
                end
                ST_SP_OV: begin
                    if (ov_res.done) begin
                        if (ov_res.suppress)
                            marks_reg[j_reg[IDXW-1:0]] <= 1'b1;
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_SP_EMIT: if (out_beat) i_reg <= i_reg + 1'b1;
                ST_CLEAR: begin
                    n_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    marks_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload holding registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RK_ILAT)
            score_i_reg <= box_rd_reg[BW-1:CW];
        if (state_reg == ST_SP_IB)
            box_a_reg <= box_rd_reg;
    end

    gbs_overlap #(
        .COORD_BITS(COORD_BITS)
    ) u_overlap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ov_start),
        .box_a     (box_a_reg[CW-1:0]),
        .box_b     (box_rd_reg[CW-1:0]),
        .mode      (mode_reg),
        .threshold (thr_reg),
        .res       (ov_res)
    );

    assign m_tdata = $bits(m_tdata)'(box_a_reg);
    assign m_tlast = last_kept;
    assign m_tuser = ovf_reg;

endmodule

// ===== src/gbs_checker.sv =====
module gbs_checker #(
    parameter int TDW = 72
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tready,
    input logic [TDW-1:0] m_tdata,
    input logic           m_tlast,
    input logic           m_tuser,
    input logic           m_tvalid,
    input logic           m_tready
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                   && $stable(m_tuser))
        else $error("stalled result changed");

    // no box taken while results are being delivered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input accepted during emission");

    // the last kept beat ends the set
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && !s_tready)
        else $error("set did not close after final beat");

    // reset leaves no result pending
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind greedy_box_suppression_unit gbs_checker #(
    .TDW($bits(m_tdata))
) u_gbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
